// ===== rtl/core/bhd_pkg.sv =====
// shared types, sizes and codes for the bucketed hash dedup table
// no dependencies
package bhd_pkg;

  localparam int BIN_INDEX_BITS = 10;
  localparam int SLOTS_PER_BIN  = 4;
  localparam int KEY_BYTES      = 8;
  localparam int VALUE_BITS     = 32;

  localparam int KEY_W      = 8 * KEY_BYTES;
  localparam int BIN_COUNT  = 1 << BIN_INDEX_BITS;
  localparam int COUNT_W    = 13;
  localparam int SCAN_W     = 5;
  localparam int ROW_W      = SLOTS_PER_BIN * (KEY_W + VALUE_BITS);
  localparam int VAL_BASE   = SLOTS_PER_BIN * KEY_W;
  localparam logic [2:0] SLOTS_RESET = 3'd4;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_LOOKUP = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_FOUND   = 3'd3;
  localparam logic [2:0] ST_MISS    = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  typedef enum logic [1:0] {OP_INSERT, OP_LOOKUP, OP_CLEAR, OP_NOP} op_t;

  typedef enum logic [1:0] {S_SWEEP, S_IDLE, S_EVAL} state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value_out;
    logic [12:0] entry_count;
  } out_item_t;

  typedef struct packed {
    op_t                       op;
    logic                      key_zero;
    logic [BIN_INDEX_BITS-1:0] bin;
    logic [KEY_W-1:0]          key;
    logic [VALUE_BITS-1:0]     value;
  } work_t;

  typedef struct packed {
    logic  valid;
    work_t item;
  } fq_head_t;

  typedef struct packed {
    logic pop;
    logic sweeping;
  } back_ctl_t;

endpackage

// ===== rtl/core/bhd_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module bhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bhd_front.sv =====
// front end: accepts input beats, classifies them and queues them for the back end
// depends on bhd_pkg
module bhd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  bhd_pkg::in_item_t   in_data,
  input  bhd_pkg::back_ctl_t  ctl,
  output bhd_pkg::fq_head_t   head
);

  bhd_pkg::work_t q_r [2];
  logic           wp_r;
  logic           rp_r;
  logic [1:0]     cnt_r;
  logic           accept;
  bhd_pkg::work_t w;

  assign in_full = (cnt_r == 2'd2) || ctl.sweeping;
  assign accept  = in_push && !in_full;

  always_comb begin
    w.key      = bhd_pkg::KEY_W'(in_data.key);
    w.value    = bhd_pkg::VALUE_BITS'(in_data.value_in);
    w.bin      = w.key[bhd_pkg::BIN_INDEX_BITS-1:0];
    w.key_zero = (w.key == '0);
    unique case (in_data.func)
      bhd_pkg::FN_INSERT: w.op = bhd_pkg::OP_INSERT;
      bhd_pkg::FN_LOOKUP: w.op = bhd_pkg::OP_LOOKUP;
      bhd_pkg::FN_CLEAR:  w.op = bhd_pkg::OP_CLEAR;
      default:            w.op = bhd_pkg::OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (accept) begin
        wp_r <= ~wp_r;
      end
      if (ctl.pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(accept) - 2'(ctl.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wp_r] <= w;
    end
  end

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rp_r];

endmodule

// ===== rtl/core/bhd_back.sv =====
// back end: bin row read, scan and write-back, clearing sweep, entry count
// depends on bhd_pkg and bhd_ram
module bhd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_wdata,
  input  bhd_pkg::fq_head_t   head,
  output bhd_pkg::back_ctl_t  ctl,
  input  logic                res_room,
  output logic                res_push,
  output bhd_pkg::out_item_t  res_data
);

  bhd_pkg::state_t                   state_r, state_nxt;
  logic [bhd_pkg::BIN_INDEX_BITS-1:0] sweep_addr_r, sweep_addr_nxt;
  logic                              sweep_op_r, sweep_op_nxt;
  logic [bhd_pkg::COUNT_W-1:0]       count_r, count_nxt;
  logic [2:0]                        slots_r;
  bhd_pkg::work_t                    cur_r;

  logic                              ram_we;
  logic [bhd_pkg::BIN_INDEX_BITS-1:0] ram_waddr;
  logic [bhd_pkg::ROW_W-1:0]         ram_wdata;
  logic [bhd_pkg::ROW_W-1:0]         rdata;
  logic [bhd_pkg::ROW_W-1:0]         new_row;

  logic [bhd_pkg::SCAN_W-1:0]        scan_n;
  logic                              hit;
  logic                              hit_empty;
  logic [bhd_pkg::VALUE_BITS-1:0]    hit_val;
  logic [63:0]                       val_wide;
  logic                              start;
  logic                              sweep_last;

  bhd_ram #(
    .WIDTH (bhd_pkg::ROW_W),
    .DEPTH (bhd_pkg::BIN_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head.item.bin),
    .rdata (rdata)
  );

  assign scan_n = (int'(slots_r) > bhd_pkg::SLOTS_PER_BIN) ?
                  bhd_pkg::SCAN_W'(bhd_pkg::SLOTS_PER_BIN) : bhd_pkg::SCAN_W'(slots_r);

  // first slot in scan range that is empty or holds the key
  always_comb begin
    logic [bhd_pkg::KEY_W-1:0] k;
    hit       = 1'b0;
    hit_empty = 1'b0;
    hit_val   = '0;
    new_row   = rdata;
    for (int s = 0; s < bhd_pkg::SLOTS_PER_BIN; s++) begin
      k = rdata[s*bhd_pkg::KEY_W +: bhd_pkg::KEY_W];
      if (!hit && (bhd_pkg::SCAN_W'(s) < scan_n)) begin
        if (k == '0) begin
          hit       = 1'b1;
          hit_empty = 1'b1;
          new_row[s*bhd_pkg::KEY_W +: bhd_pkg::KEY_W] = cur_r.key;
          new_row[bhd_pkg::VAL_BASE + s*bhd_pkg::VALUE_BITS +: bhd_pkg::VALUE_BITS] =
            cur_r.value;
        end else if (k == cur_r.key) begin
          hit     = 1'b1;
          hit_val = rdata[bhd_pkg::VAL_BASE + s*bhd_pkg::VALUE_BITS +: bhd_pkg::VALUE_BITS];
        end
      end
    end
  end

  assign val_wide   = 64'(hit_val);
  assign start      = head.valid && res_room;
  assign sweep_last = (sweep_addr_r == '1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bhd_pkg::S_SWEEP: if (sweep_last) state_nxt = bhd_pkg::S_IDLE;
      bhd_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (head.item.op == bhd_pkg::OP_CLEAR) ? bhd_pkg::S_SWEEP : bhd_pkg::S_EVAL;
        end
      end
      bhd_pkg::S_EVAL: state_nxt = bhd_pkg::S_IDLE;
      default: state_nxt = bhd_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl.pop            = 1'b0;
    ctl.sweeping       = (state_r == bhd_pkg::S_SWEEP);
    ram_we             = 1'b0;
    ram_waddr          = cur_r.bin;
    ram_wdata          = new_row;
    res_push           = 1'b0;
    res_data.status    = bhd_pkg::ST_MISS;
    res_data.value_out = '0;
    count_nxt          = count_r;
    sweep_addr_nxt     = sweep_addr_r;
    sweep_op_nxt       = sweep_op_r;
    unique case (state_r)
      bhd_pkg::S_SWEEP: begin
        ram_we         = 1'b1;
        ram_waddr      = sweep_addr_r;
        ram_wdata      = '0;
        sweep_addr_nxt = sweep_addr_r + 1'b1;
        if (sweep_last && sweep_op_r) begin
          res_push        = 1'b1;
          res_data.status = bhd_pkg::ST_CLEARED;
          sweep_op_nxt    = 1'b0;
        end
      end
      bhd_pkg::S_IDLE: begin
        if (start) begin
          ctl.pop = 1'b1;
          if (head.item.op == bhd_pkg::OP_CLEAR) begin
            count_nxt      = '0;
            sweep_addr_nxt = '0;
            sweep_op_nxt   = 1'b1;
          end
        end
      end
      bhd_pkg::S_EVAL: begin
        res_push = 1'b1;
        case (cur_r.op)
          bhd_pkg::OP_INSERT: begin
            if (cur_r.key_zero || !hit) begin
              res_data.status = bhd_pkg::ST_FULL;
            end else if (hit_empty) begin
              res_data.status = bhd_pkg::ST_STORED;
              ram_we          = 1'b1;
              count_nxt       = count_r + 1'b1;
            end else begin
              res_data.status = bhd_pkg::ST_DUP;
            end
          end
          bhd_pkg::OP_LOOKUP: begin
            if (!cur_r.key_zero && hit && !hit_empty) begin
              res_data.status    = bhd_pkg::ST_FOUND;
              res_data.value_out = val_wide[31:0];
            end
          end
          default: res_data.status = bhd_pkg::ST_MISS;
        endcase
      end
      default: ;
    endcase
    res_data.entry_count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bhd_pkg::S_SWEEP;
      sweep_addr_r <= '0;
      sweep_op_r   <= 1'b0;
      count_r      <= '0;
      slots_r      <= bhd_pkg::SLOTS_RESET;
    end else begin
      state_r      <= state_nxt;
      sweep_addr_r <= sweep_addr_nxt;
      sweep_op_r   <= sweep_op_nxt;
      count_r      <= count_nxt;
      if (cfg_we) begin
        slots_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur_r <= head.item;
    end
  end

endmodule

// ===== rtl/core/bhd_outq.sv =====
// two-entry result queue in front of the out_ ports
// depends on bhd_pkg
module bhd_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               res_push,
  input  bhd_pkg::out_item_t res_data,
  output logic               res_room,
  output logic               out_empty,
  input  logic               out_pop,
  output bhd_pkg::out_item_t out_data
);

  bhd_pkg::out_item_t q_r [2];
  logic               wp_r;
  logic               rp_r;
  logic [1:0]         cnt_r;
  logic               deq;

  assign out_empty = (cnt_r == 2'd0);
  assign res_room  = (cnt_r != 2'd2);
  assign deq       = out_pop && !out_empty;
  assign out_data  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (res_push) begin
        wp_r <= ~wp_r;
      end
      if (deq) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(res_push) - 2'(deq);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wp_r] <= res_data;
    end
  end

endmodule

// ===== rtl/core/bucketed_hash_dedup_table.sv =====
// a beat waits in the front queue until S_IDLE pops it and reads its bin row, if the result
// queue has room; S_EVAL scans the row, writes it back on a store and pushes the result
// clear sweeps one bin row per cycle over all 1024 rows; its result is pushed with the last row
// reset: synchronous active low; a sweep then zeroes all 1024 rows, in_full stays high meanwhile
// depends on bhd_pkg, bhd_front, bhd_back, bhd_outq, bhd_ram
module bucketed_hash_dedup_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  bhd_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output bhd_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata
);

  bhd_pkg::fq_head_t  head;
  bhd_pkg::back_ctl_t ctl;
  logic               res_room;
  logic               res_push;
  bhd_pkg::out_item_t res_data;

  bhd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .ctl     (ctl),
    .head    (head)
  );

  bhd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .ctl       (ctl),
    .res_room  (res_room),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  bhd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_data  (res_data),
    .res_room  (res_room),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/bhd_checker.sv =====
// port-level checks for the bucketed hash dedup table, bound to the top level
// depends on bhd_pkg
module bhd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input bhd_pkg::out_item_t out_data
);

  // reset starts the clearing sweep with nothing waiting
  a_reset_sweep: assert property (@(posedge clk) !rst_n |=> out_empty && in_full)
    else $error("no sweep after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status != bhd_pkg::ST_FOUND |-> out_data.value_out == '0)
    else $error("value without a find");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status == bhd_pkg::ST_CLEARED |-> out_data.entry_count == '0)
    else $error("count after clear");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.status <= bhd_pkg::ST_CLEARED)
    else $error("bad status code");

endmodule

bind bucketed_hash_dedup_table bhd_checker u_bhd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

// ===== tb/tb_top.sv =====
// testbench for bucketed_hash_dedup_table: directed and random insert, lookup and clear beats
// checked against a behavioral copy of the table; depends on bhd_pkg and the table rtl
`timescale 1ns / 1ps
module tb_top;

  localparam int DEPTH = bhd_pkg::BIN_COUNT * bhd_pkg::SLOTS_PER_BIN;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  bhd_pkg::in_item_t in_data = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  bhd_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_wdata = '0;

  bucketed_hash_dedup_table u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // table copy
  logic [63:0] tbl_keys [DEPTH];
  logic [31:0] tbl_vals [DEPTH];
  logic [12:0] tbl_count;
  logic [2:0] tbl_slots;
  bhd_pkg::out_item_t expected_q[$];

  int errors = 0;
  int idle_in = 0;
  int idle_out = 0;
  int stall_cnt = 0;
  logic [63:0] used_keys[$];

  initial forever #5 clk = ~clk;

  function automatic bhd_pkg::out_item_t table_apply(bhd_pkg::in_item_t it);
    bhd_pkg::out_item_t r;
    int base, n;
    logic done;
    r = '0;
    r.status = bhd_pkg::ST_MISS;
    base = int'(it.key[bhd_pkg::BIN_INDEX_BITS-1:0]) * bhd_pkg::SLOTS_PER_BIN;
    n = (tbl_slots > bhd_pkg::SLOTS_PER_BIN) ? bhd_pkg::SLOTS_PER_BIN : int'(tbl_slots);
    done = 1'b0;
    if (it.func == bhd_pkg::FN_INSERT) begin
      r.status = bhd_pkg::ST_FULL;
      if (it.key != 0) begin
        for (int i = 0; i < n; i++) begin
          if (!done && tbl_keys[base+i] == 0) begin
            tbl_keys[base+i] = it.key;
            tbl_vals[base+i] = it.value_in;
            tbl_count++;
            r.status = bhd_pkg::ST_STORED;
            done = 1'b1;
          end else if (!done && tbl_keys[base+i] == it.key) begin
            r.status = bhd_pkg::ST_DUP;
            done = 1'b1;
          end
        end
      end
    end else if (it.func == bhd_pkg::FN_LOOKUP) begin
      if (it.key != 0) begin
        for (int i = 0; i < n; i++) begin
          if (!done && tbl_keys[base+i] == it.key) begin
            r.status = bhd_pkg::ST_FOUND;
            r.value_out = tbl_vals[base+i];
            done = 1'b1;
          end else if (!done && tbl_keys[base+i] == 0) begin
            done = 1'b1;
          end
        end
      end
    end else if (it.func == bhd_pkg::FN_CLEAR) begin
      foreach (tbl_keys[i]) tbl_keys[i] = '0;
      tbl_count = '0;
      r.status = bhd_pkg::ST_CLEARED;
    end
    r.entry_count = tbl_count;
    return r;
  endfunction

  // one beat into the table, waiting out full and the sender idle ratio
  task automatic send_item(logic [1:0] f, logic [63:0] k, logic [31:0] v);
    bhd_pkg::in_item_t it;
    it.func = f;
    it.key = k;
    it.value_in = v;
    while ($urandom_range(99) < idle_in) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    expected_q.push_back(table_apply(it));
    if (k != 0) used_keys.push_back(k);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_slots(logic [2:0] n);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_slots = n;
  endtask

  // keys crowded into a few bins so bins fill and duplicates occur
  function automatic logic [63:0] pick_key();
    int c;
    logic [63:0] k;
    c = $urandom_range(99);
    if (c < 35 && used_keys.size() != 0) return used_keys[$urandom_range(used_keys.size()-1)];
    k = {$urandom, $urandom};
    if (c < 80) k[bhd_pkg::BIN_INDEX_BITS-1:0] = bhd_pkg::BIN_INDEX_BITS'($urandom_range(7));
    if (c == 99) k = '0;
    return k;
  endfunction

  // result side: pop with stalls, compare against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat status=%0d", out_data.status);
        errors++;
      end else begin
        bhd_pkg::out_item_t e;
        e = expected_q.pop_front();
        if (out_data.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_data.status);
          errors++;
        end
        if (out_data.value_out !== e.value_out) begin
          $error("value_out exp %h got %h", e.value_out, out_data.value_out);
          errors++;
        end
        if (out_data.entry_count !== e.entry_count) begin
          $error("entry_count exp %0d got %0d", e.entry_count, out_data.entry_count);
          errors++;
        end
      end
    end
    out_pop <= ($urandom_range(99) >= idle_out);
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) stall_cnt <= 0;
    else if (rst_n) stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    logic [63:0] k;
    k = 64'h0123_4567_89ab_c005;
    send_item(bhd_pkg::FN_LOOKUP, k, 32'h0);
    send_item(bhd_pkg::FN_INSERT, k, 32'hffff_ffff);
    send_item(bhd_pkg::FN_INSERT, k, 32'h1);
    send_item(bhd_pkg::FN_LOOKUP, k, 32'h0);
    send_item(bhd_pkg::FN_INSERT, 64'h0, 32'h5);
    send_item(bhd_pkg::FN_LOOKUP, 64'h0, 32'h0);
    send_item(bhd_pkg::FN_INSERT, 64'hffff_ffff_ffff_ffff, 32'h0);
    send_item(bhd_pkg::FN_LOOKUP, 64'hffff_ffff_ffff_ffff, 32'h0);
    for (int i = 1; i <= 5; i++) begin
      send_item(bhd_pkg::FN_INSERT, {56'(i), 8'h05} + 64'h200, 32'(i));
    end
    send_item(bhd_pkg::FN_LOOKUP, 64'h9905, 32'h0);
    send_item(2'd3, k, 32'h7);
    send_item(bhd_pkg::FN_CLEAR, 64'h0, 32'h0);
    send_item(bhd_pkg::FN_LOOKUP, k, 32'h0);
  endtask

  task automatic test_slots_extremes();
    logic [2:0] vals[5] = '{3'd1, 3'd0, 3'd7, 3'd4, 3'd2};
    foreach (vals[j]) begin
      set_slots(vals[j]);
      for (int i = 0; i < 6; i++) begin
        send_item(bhd_pkg::FN_INSERT, {48'(i+1), 16'h0033}, $urandom);
      end
      send_item(bhd_pkg::FN_LOOKUP, {48'd3, 16'h0033}, 32'h0);
      send_item(bhd_pkg::FN_CLEAR, 64'h0, 32'h0);
    end
    set_slots(bhd_pkg::SLOTS_RESET);
  endtask

  task automatic test_random();
    int ph[4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{7, 7}};
    int c;
    logic [1:0] f;
    for (int p = 0; p < 4; p++) begin
      idle_in = ph[p][0];
      idle_out = ph[p][1];
      if (p == 2) set_slots(3'($urandom_range(1, 4)));
      for (int i = 0; i < 490; i++) begin
        c = $urandom_range(199);
        f = (c < 110) ? bhd_pkg::FN_INSERT : (c < 197) ? bhd_pkg::FN_LOOKUP :
            (c < 198) ? 2'd3 : bhd_pkg::FN_CLEAR;
        if (f == bhd_pkg::FN_CLEAR) used_keys.delete();
        send_item(f, pick_key(), $urandom);
      end
    end
    idle_in = 0;
    idle_out = 0;
  endtask

  task automatic test_pause_until_drained();
    send_item(bhd_pkg::FN_INSERT, 64'h0000_0001_0000_0100, 32'hdead_beef);
    drain();
    send_item(bhd_pkg::FN_LOOKUP, 64'h0000_0001_0000_0100, 32'h0);
  endtask

  initial begin
    foreach (tbl_keys[i]) begin
      tbl_keys[i] = '0;
      tbl_vals[i] = '0;
    end
    tbl_count = '0;
    tbl_slots = bhd_pkg::SLOTS_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_slots_extremes();
    test_random();
    test_pause_until_drained();
    drain();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/bhd_pkg.sv
rtl/core/bhd_ram.sv
rtl/core/bhd_front.sv
rtl/core/bhd_back.sv
rtl/core/bhd_outq.sv
rtl/core/bucketed_hash_dedup_table.sv
rtl/core/bhd_checker.sv
tb/tb_top.sv
